// ===== rtl/pfct_pkg.sv =====
// ----------------------------------------------------------------------------
// pfct_pkg
// Shared widths, codes and types of the per-client flow counter table.
// ----------------------------------------------------------------------------
package pfct_pkg;

  localparam int NUM_SERVICES   = 8;
  localparam int MAX_CLIENTS    = 64;
  localparam int NUM_SLOT_REGS  = 8;

  localparam int SLOT_W         = 49;
  localparam int SLOT_VALID_BIT = 48;
  localparam int ADDR_W         = 32;
  localparam int PORT_W         = 16;
  localparam int CNT_W          = 64;
  localparam int LEN_W          = 16;
  localparam int BITS_W         = LEN_W + 3;
  localparam int COUNT_W        = 7;
  localparam int SEL_W          = 3;
  localparam int ENTSEL_W       = 6;
  localparam int STATUS_W       = 3;
  localparam int OP_W           = 2;
  localparam int PROTO_W        = 8;
  localparam int CFG_IDX_W      = 3;

  localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;

  localparam int ENT_W   = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int SVC_W   = (NUM_SERVICES > 1) ? $clog2(NUM_SERVICES) : 1;
  localparam int DEPTH   = NUM_SERVICES * MAX_CLIENTS;
  localparam int DEPTH_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HELD_W  = $clog2(MAX_CLIENTS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_INGRESS = 2'd0,
    OP_EGRESS  = 2'd1,
    OP_READ    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE       = 3'd0,
    ST_IGNORED    = 3'd1,
    ST_NO_SERVICE = 3'd2,
    ST_NO_CLIENT  = 3'd3,
    ST_FULL       = 3'd4,
    ST_EMPTY      = 3'd5
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  rx_packets;
    logic [CNT_W-1:0]  rx_bits;
    logic [CNT_W-1:0]  tx_packets;
    logic [CNT_W-1:0]  tx_bits;
  } entry_t;

  function automatic logic [DEPTH_W-1:0] ent_index(logic [SVC_W-1:0] s,
                                                   logic [ENT_W-1:0] e);
    logic [DEPTH_W-1:0] base;
    base = DEPTH_W'(DEPTH_W'(s) * DEPTH_W'(MAX_CLIENTS));
    return DEPTH_W'(base + DEPTH_W'(e));
  endfunction

endpackage

// ===== rtl/pfct_if.sv =====
// ----------------------------------------------------------------------------
// pfct_in_if / pfct_out_if
// Valid/ready channels for packet items and result items.
// ----------------------------------------------------------------------------
interface pfct_in_if;
  logic                            valid;
  logic                            ready;
  logic [pfct_pkg::OP_W-1:0]       operation;
  logic                            is_ipv4;
  logic [pfct_pkg::PROTO_W-1:0]    protocol;
  logic [pfct_pkg::ADDR_W-1:0]     src_addr;
  logic [pfct_pkg::ADDR_W-1:0]     dst_addr;
  logic [pfct_pkg::PORT_W-1:0]     src_port;
  logic [pfct_pkg::PORT_W-1:0]     dst_port;
  logic [pfct_pkg::LEN_W-1:0]      total_length;
  logic [pfct_pkg::SEL_W-1:0]      slot_select;
  logic [pfct_pkg::ENTSEL_W-1:0]   entry_select;

  modport source(output valid, operation, is_ipv4, protocol, src_addr, dst_addr,
                 src_port, dst_port, total_length, slot_select, entry_select,
                 input ready);
  modport sink(input valid, operation, is_ipv4, protocol, src_addr, dst_addr,
               src_port, dst_port, total_length, slot_select, entry_select,
               output ready);
endinterface

interface pfct_out_if;
  logic                            valid;
  logic                            ready;
  logic [pfct_pkg::STATUS_W-1:0]   status;
  logic [pfct_pkg::ADDR_W-1:0]     client_addr;
  logic [pfct_pkg::CNT_W-1:0]      rx_packets;
  logic [pfct_pkg::CNT_W-1:0]      rx_bits;
  logic [pfct_pkg::CNT_W-1:0]      tx_packets;
  logic [pfct_pkg::CNT_W-1:0]      tx_bits;
  logic [pfct_pkg::COUNT_W-1:0]    client_count;

  modport source(output valid, status, client_addr, rx_packets, rx_bits,
                 tx_packets, tx_bits, client_count, input ready);
  modport sink(input valid, status, client_addr, rx_packets, rx_bits,
               tx_packets, tx_bits, client_count, output ready);
endinterface

// ===== rtl/per_client_flow_counter_table_core.sv =====
// ----------------------------------------------------------------------------
// per_client_flow_counter_table_core
// Per-service, per-client TCP/IPv4 packet and bit counters in one table memory.
// ----------------------------------------------------------------------------
// All client entries (valid, address, four 64-bit counters) live in a single
// memory of NUM_SERVICES*MAX_CLIENTS words with a registered read port. After
// reset a clearing pass writes every word once before the first item is
// taken. An ingress or egress packet walks its service's client table one
// entry per cycle through the memory read port and stops when it finds the
// client; packets that are not TCP/IPv4 or match no service go straight to
// the result. A read fetches the selected entry; a clear sweeps the table
// of its service. Writing a service slot starts a clearing pass of its
// table, during which no item is taken.
// ----------------------------------------------------------------------------
module per_client_flow_counter_table_core (
  input  logic                              clk,
  input  logic                              rst,
  pfct_in_if.sink                           pkt,
  pfct_out_if.source                        res,
  input  logic                              cfg_we,
  input  logic [pfct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfct_pkg::SLOT_W-1:0]       cfg_data
);

  localparam int NSVC  = pfct_pkg::NUM_SERVICES;
  localparam int NMAX  = pfct_pkg::MAX_CLIENTS;
  localparam int DW    = pfct_pkg::DEPTH_W;
  localparam int EW    = pfct_pkg::ENT_W;
  localparam int SW    = pfct_pkg::SVC_W;
  localparam int HW    = pfct_pkg::HELD_W;
  localparam int CW    = pfct_pkg::CNT_W;
  localparam int AW    = pfct_pkg::ADDR_W;
  localparam int VB    = pfct_pkg::SLOT_VALID_BIT;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_SCAN  = 6'b000100,
    S_READ  = 6'b001000,
    S_UPD   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t                              state;
  logic [pfct_pkg::SLOT_W-1:0]         slot_reg [pfct_pkg::NUM_SLOT_REGS];
  logic [HW-1:0]                       clients_held [NSVC];
  logic [NSVC-1:0]                     pend;

  pfct_pkg::entry_t                    mem [pfct_pkg::DEPTH];
  pfct_pkg::entry_t                    mem_rdata;
  logic [DW-1:0]                       mem_raddr;
  logic                                mem_we;
  logic [DW-1:0]                       mem_waddr;
  pfct_pkg::entry_t                    mem_wdata;

  pfct_pkg::op_t                       op_q;
  logic [SW-1:0]                       svc_q;
  logic [AW-1:0]                       key_q;
  logic [pfct_pkg::BITS_W-1:0]         bits_q;

  logic [DW-1:0]                       swp;
  logic [DW-1:0]                       swp_end;
  logic                                clr_res;

  logic [EW-1:0]                       iss_e;
  logic                                iss_done;
  logic                                chk_vld;
  logic [EW-1:0]                       chk_e;
  logic                                hit;
  logic [EW-1:0]                       hit_e;
  logic                                free_found;
  logic [EW-1:0]                       free_e;
  pfct_pkg::entry_t                    cur;

  pfct_pkg::status_t                   res_status;
  pfct_pkg::entry_t                    res_entry;
  logic                                res_has_entry;
  logic                                res_has_svc;

  logic                                out_valid;

  logic                                svc_match;
  logic [SW-1:0]                       svc_hit;
  logic [AW-1:0]                       m_addr;
  logic [pfct_pkg::PORT_W-1:0]         m_port;
  logic                                sel_live;
  logic                                pend_any;
  logic [SW-1:0]                       pend_svc;
  logic                                tbl_full;
  logic                                fin_go;
  pfct_pkg::entry_t                    upd_base;
  pfct_pkg::entry_t                    upd_entry;

  // service match, lowest slot wins
  always_comb begin
    m_addr    = (pkt.operation == pfct_pkg::OP_INGRESS) ? pkt.dst_addr : pkt.src_addr;
    m_port    = (pkt.operation == pfct_pkg::OP_INGRESS) ? pkt.dst_port : pkt.src_port;
    svc_match = 1'b0;
    svc_hit   = '0;
    for (int s = NSVC - 1; s >= 0; s--) begin
      if (slot_reg[s][VB] && slot_reg[s][VB-1:16] == m_addr &&
          slot_reg[s][15:0] == m_port) begin
        svc_match = 1'b1;
        svc_hit   = SW'(s);
      end
    end
  end

  always_comb begin
    sel_live = (int'(pkt.slot_select) < NSVC) && slot_reg[pkt.slot_select][VB];
  end

  always_comb begin
    pend_any = |pend;
    pend_svc = '0;
    for (int s = NSVC - 1; s >= 0; s--) begin
      if (pend[s]) begin
        pend_svc = SW'(s);
      end
    end
  end

  assign pkt.ready = (state == S_IDLE) && !pend_any;
  assign tbl_full  = clients_held[svc_q] >= HW'(NMAX);
  assign fin_go    = !out_valid || res.ready;

  // read-modify-write value for the found or newly allocated entry
  always_comb begin
    upd_base = '0;
    if (hit) begin
      upd_base = cur;
    end else begin
      upd_base.valid = 1'b1;
      upd_base.addr  = key_q;
    end
    upd_entry = upd_base;
    if (op_q == pfct_pkg::OP_INGRESS) begin
      upd_entry.rx_packets = upd_base.rx_packets + CW'(1);
      upd_entry.rx_bits    = upd_base.rx_bits + CW'(bits_q);
    end else begin
      upd_entry.tx_packets = upd_base.tx_packets + CW'(1);
      upd_entry.tx_bits    = upd_base.tx_bits + CW'(bits_q);
    end
  end

  always_comb begin
    if (state == S_IDLE) begin
      mem_raddr = pfct_pkg::ent_index(SW'(pkt.slot_select), EW'(pkt.entry_select));
    end else begin
      mem_raddr = pfct_pkg::ent_index(svc_q, iss_e);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = swp;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_UPD) begin
      mem_we    = hit || (op_q == pfct_pkg::OP_INGRESS && !tbl_full);
      mem_waddr = pfct_pkg::ent_index(svc_q, hit ? hit_e : free_e);
      mem_wdata = upd_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      swp       <= '0;
      swp_end   <= DW'(pfct_pkg::DEPTH - 1);
      clr_res   <= 1'b0;
      pend      <= '0;
      out_valid <= 1'b0;
      svc_q     <= '0;
      iss_done  <= 1'b0;
      chk_vld   <= 1'b0;
      hit       <= 1'b0;
      free_found <= 1'b0;
      for (int i = 0; i < pfct_pkg::NUM_SLOT_REGS; i++) begin
        slot_reg[i] <= '0;
      end
      for (int s = 0; s < NSVC; s++) begin
        clients_held[s] <= '0;
      end
    end else begin
      if (state == S_FIN && fin_go) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (pend_any) begin
            pend[pend_svc] <= 1'b0;
            swp            <= pfct_pkg::ent_index(pend_svc, '0);
            swp_end        <= pfct_pkg::ent_index(pend_svc, EW'(NMAX - 1));
            clr_res        <= 1'b0;
            state          <= S_CLEAR;
          end else if (pkt.valid) begin
            op_q          <= pfct_pkg::op_t'(pkt.operation);
            bits_q        <= {pkt.total_length, 3'b000};
            res_entry     <= '0;
            res_has_entry <= 1'b0;
            res_has_svc   <= 1'b0;
            case (pkt.operation) inside
              pfct_pkg::OP_INGRESS, pfct_pkg::OP_EGRESS: begin
                if (!pkt.is_ipv4 || pkt.protocol != pfct_pkg::PROTO_TCP) begin
                  res_status <= pfct_pkg::ST_IGNORED;
                  state      <= S_FIN;
                end else if (!svc_match) begin
                  res_status <= pfct_pkg::ST_NO_SERVICE;
                  state      <= S_FIN;
                end else begin
                  svc_q      <= svc_hit;
                  key_q      <= (pkt.operation == pfct_pkg::OP_INGRESS) ?
                                pkt.src_addr : pkt.dst_addr;
                  iss_e      <= '0;
                  iss_done   <= 1'b0;
                  chk_vld    <= 1'b0;
                  hit        <= 1'b0;
                  free_found <= 1'b0;
                  state      <= S_SCAN;
                end
              end
              pfct_pkg::OP_READ: begin
                svc_q <= SW'(pkt.slot_select);
                if (!sel_live) begin
                  res_status <= pfct_pkg::ST_NO_SERVICE;
                  state      <= S_FIN;
                end else if (int'(pkt.entry_select) >= NMAX) begin
                  res_status  <= pfct_pkg::ST_EMPTY;
                  res_has_svc <= 1'b1;
                  state       <= S_FIN;
                end else begin
                  // read issued this cycle at the selected entry
                  state <= S_READ;
                end
              end
              default: begin
                svc_q <= SW'(pkt.slot_select);
                if (!sel_live) begin
                  res_status <= pfct_pkg::ST_NO_SERVICE;
                  state      <= S_FIN;
                end else begin
                  clients_held[SW'(pkt.slot_select)] <= '0;
                  swp         <= pfct_pkg::ent_index(SW'(pkt.slot_select), '0);
                  swp_end     <= pfct_pkg::ent_index(SW'(pkt.slot_select),
                                                     EW'(NMAX - 1));
                  clr_res     <= 1'b1;
                  res_status  <= pfct_pkg::ST_DONE;
                  res_has_svc <= 1'b1;
                  state       <= S_CLEAR;
                end
              end
            endcase
          end
        end

        S_CLEAR: begin
          swp <= DW'(swp + DW'(1));
          if (swp == swp_end) begin
            state <= clr_res ? S_FIN : S_IDLE;
          end
        end

        S_SCAN: begin
          // one read issued and one entry checked per cycle
          if (!iss_done) begin
            iss_e <= EW'(iss_e + EW'(1));
            if (iss_e == EW'(NMAX - 1)) begin
              iss_done <= 1'b1;
            end
          end
          chk_vld <= !iss_done;
          chk_e   <= iss_e;
          if (chk_vld) begin
            if (mem_rdata.valid && mem_rdata.addr == key_q) begin
              hit   <= 1'b1;
              hit_e <= chk_e;
              cur   <= mem_rdata;
              state <= S_UPD;
            end else begin
              if (!mem_rdata.valid && !free_found) begin
                free_found <= 1'b1;
                free_e     <= chk_e;
              end
              if (chk_e == EW'(NMAX - 1)) begin
                state <= S_UPD;
              end
            end
          end
        end

        S_READ: begin
          res_has_svc <= 1'b1;
          if (mem_rdata.valid) begin
            res_status    <= pfct_pkg::ST_DONE;
            res_entry     <= mem_rdata;
            res_has_entry <= 1'b1;
          end else begin
            res_status <= pfct_pkg::ST_EMPTY;
          end
          state <= S_FIN;
        end

        S_UPD: begin
          res_has_svc <= 1'b1;
          state       <= S_FIN;
          if (hit) begin
            res_status    <= pfct_pkg::ST_DONE;
            res_entry     <= upd_entry;
            res_has_entry <= 1'b1;
          end else if (op_q == pfct_pkg::OP_EGRESS) begin
            res_status <= pfct_pkg::ST_NO_CLIENT;
          end else if (tbl_full) begin
            res_status <= pfct_pkg::ST_FULL;
          end else begin
            clients_held[svc_q] <= HW'(clients_held[svc_q] + HW'(1));
            res_status    <= pfct_pkg::ST_DONE;
            res_entry     <= upd_entry;
            res_has_entry <= 1'b1;
          end
        end

        S_FIN: begin
          if (fin_go) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // the user must write slots only while idle; the block does not enforce this; the table sweep follows
      if (cfg_we) begin
        slot_reg[cfg_index] <= cfg_data;
        if (int'(cfg_index) < NSVC) begin
          pend[SW'(cfg_index)]         <= 1'b1;
          clients_held[SW'(cfg_index)] <= '0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_FIN && fin_go) begin
      res.status      <= res_status;
      res.client_addr <= res_has_entry ? res_entry.addr : '0;
      res.rx_packets  <= res_has_entry ? res_entry.rx_packets : '0;
      res.rx_bits     <= res_has_entry ? res_entry.rx_bits : '0;
      res.tx_packets  <= res_has_entry ? res_entry.tx_packets : '0;
      res.tx_bits     <= res_has_entry ? res_entry.tx_bits : '0;
      res.client_count <= res_has_svc ?
                          pfct_pkg::COUNT_W'(clients_held[svc_q]) : '0;
    end
  end

  assign res.valid = out_valid;

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    clients_held[svc_q] <= HW'(NMAX))
    else $error("client count above table size");

  a_alloc_has_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && !hit && op_q == pfct_pkg::OP_INGRESS && !tbl_full)
      |-> free_found)
    else $error("allocation without a free entry");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (pkt.valid && pkt.ready) |=> !pkt.ready)
    else $error("second item taken while one is at work");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && fin_go) |=> (out_valid && state == S_IDLE))
    else $error("result not presented");

endmodule
